// ----- rtl/bfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;
   localparam int NUM_FRAMES    = 4096;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_AW       = $clog2(MAP_WORDS);
   localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
   localparam int FRAME_W       = WORD_AW + BIT_AW;
   localparam int TOTAL_W       = FRAME_W + 1;

   localparam logic [2:0] CMD_ALLOC_ONE  = 3'd0;
   localparam logic [2:0] CMD_ALLOC_RUN  = 3'd1;
   localparam logic [2:0] CMD_MARK_RANGE = 3'd2;
   localparam logic [2:0] CMD_FREE_ONE   = 3'd3;
   localparam logic [2:0] CMD_FREE_RANGE = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_ZERO_COUNT = 2'd2;
   localparam logic [1:0] ST_BEYOND     = 2'd3;

   localparam logic [1:0] REG_FRAMES_TOTAL = 2'd0;

   typedef struct packed {
      logic [2:0]  command;
      logic [11:0] frame_index;
      logic [12:0] frame_count;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] start_frame;
   } rsp_word_type;
endpackage

// ----- rtl/bfa_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_stream_if
// Valid/ready channel carrying one word.
// ----------------------------------------------------------------------------
interface bfa_stream_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bitmap_frame_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// First-fit page frame allocator over a used-bit map held in a word memory.
// ----------------------------------------------------------------------------
// channel  dir  word
// req      in   command, frame_index, frame_count
// rsp      out  status, start_frame
// csr      in   APB, frames_total at 0x0
//
// Commands that pass their checks sweep the map bit by bit through one shared
// bit-position counter. A scan reads each map word (read, wait) and then
// evaluates its bits in turn; a fill reads, waits and writes for each frame.
// Worst case is an alloc run over the whole map; every command also passes
// through the check and done states.
// After reset a clearing pass zeroes all MAP_WORDS map words before req is ready.
// req is low while a command runs or its response waits on rsp.
module bitmap_frame_allocator_core (
   input  logic        clock,
   input  logic        reset,
   bfa_stream_if.sink   req,
   bfa_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int FW = bfa_pkg::FRAME_W;
   localparam int TW = bfa_pkg::TOTAL_W;
   localparam int WB = bfa_pkg::MAP_WORD_BITS;
   localparam int AW = bfa_pkg::WORD_AW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_EV,
      S_FILL_RD, S_FILL_WAIT, S_FILL_WR, S_DONE
   } state_type;

   state_type state_ff;
   logic [12:0] total_reg_ff;
   logic [2:0]  cmd_ff;
   logic [11:0] idx_ff;
   logic [12:0] cnt_ff;
   logic [TW-1:0] pos_ff;
   logic [TW-1:0] run_ff;
   logic [TW-1:0] start_ff;
   logic [TW-1:0] end_ff;
   logic          set_ff;
   logic [1:0]  st_ff;
   logic        rsp_valid_ff;

   logic [WB-1:0] mem [bfa_pkg::MAP_WORDS];
   logic [WB-1:0] rd_ff;
   logic [AW-1:0] clr_ff;

   logic [TW-1:0] eff_total;
   logic [TW:0]   range_end;
   logic          bit_now;
   logic          csr_wr;

   assign eff_total = (total_reg_ff > 13'(bfa_pkg::NUM_FRAMES))
                      ? TW'(bfa_pkg::NUM_FRAMES) : TW'(total_reg_ff);
   assign range_end = (TW+1)'(idx_ff) + (TW+1)'(cnt_ff);
   assign bit_now   = rd_ff[pos_ff[bfa_pkg::BIT_AW-1:0]];
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == bfa_pkg::REG_FRAMES_TOTAL) ? {19'd0, total_reg_ff} : 32'd0;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data.status = st_ff;
   assign rsp.data.start_frame = (st_ff == bfa_pkg::ST_OK &&
      (cmd_ff == bfa_pkg::CMD_ALLOC_ONE || cmd_ff == bfa_pkg::CMD_ALLOC_RUN ||
       cmd_ff == bfa_pkg::CMD_MARK_RANGE)) ? start_ff[11:0] : 12'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_reg_ff <= 13'd4096;
      end else if (csr_wr && csr_paddr == bfa_pkg::REG_FRAMES_TOTAL) begin
         total_reg_ff <= csr_pwdata[12:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (state_ff == S_FILL_WR) begin
         mem[pos_ff[FW-1:bfa_pkg::BIT_AW]] <= set_ff
            ? (rd_ff | (WB'(1) << pos_ff[bfa_pkg::BIT_AW-1:0]))
            : (rd_ff & ~(WB'(1) << pos_ff[bfa_pkg::BIT_AW-1:0]));
      end
      rd_ff <= mem[pos_ff[FW-1:bfa_pkg::BIT_AW]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(bfa_pkg::MAP_WORDS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cmd_ff <= req.data.command;
                  idx_ff <= req.data.frame_index;
                  cnt_ff <= req.data.frame_count;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               st_ff    <= bfa_pkg::ST_OK;
               start_ff <= '0;
               pos_ff   <= '0;
               run_ff   <= '0;
               state_ff <= S_DONE;
               case (cmd_ff)
                  bfa_pkg::CMD_ALLOC_ONE, bfa_pkg::CMD_ALLOC_RUN: begin
                     if (cmd_ff == bfa_pkg::CMD_ALLOC_RUN && cnt_ff == 13'd0) begin
                        st_ff <= bfa_pkg::ST_ZERO_COUNT;
                     end else if (cmd_ff == bfa_pkg::CMD_ALLOC_ONE) begin
                        cnt_ff <= 13'd1;
                        if (eff_total == '0) st_ff <= bfa_pkg::ST_NO_SPACE;
                        else state_ff <= S_SCAN_RD;
                     end else if (TW'(cnt_ff) > eff_total) begin
                        st_ff <= bfa_pkg::ST_NO_SPACE;
                     end else begin
                        state_ff <= S_SCAN_RD;
                     end
                  end
                  bfa_pkg::CMD_MARK_RANGE, bfa_pkg::CMD_FREE_RANGE: begin
                     if (cnt_ff == 13'd0) st_ff <= bfa_pkg::ST_ZERO_COUNT;
                     else if (range_end > (TW+1)'(eff_total)) st_ff <= bfa_pkg::ST_BEYOND;
                     else begin
                        start_ff <= TW'(idx_ff);
                        pos_ff   <= TW'(idx_ff);
                        end_ff   <= range_end[TW-1:0];
                        set_ff   <= (cmd_ff == bfa_pkg::CMD_MARK_RANGE);
                        state_ff <= S_FILL_RD;
                     end
                  end
                  bfa_pkg::CMD_FREE_ONE: begin
                     if (TW'(idx_ff) >= eff_total) st_ff <= bfa_pkg::ST_BEYOND;
                     else begin
                        pos_ff   <= TW'(idx_ff);
                        end_ff   <= TW'(idx_ff) + 1'b1;
                        set_ff   <= 1'b0;
                        state_ff <= S_FILL_RD;
                     end
                  end
                  default: ;
               endcase
            end
            S_SCAN_RD: state_ff <= S_SCAN_WAIT;
            S_SCAN_WAIT: state_ff <= S_SCAN_EV;
            S_SCAN_EV: begin
               if (bit_now) begin
                  run_ff <= '0;
                  start_ff <= pos_ff + 1'b1;
               end else if (run_ff + 1'b1 == TW'(cnt_ff)) begin
                  pos_ff   <= start_ff;
                  end_ff   <= pos_ff + 1'b1;
                  set_ff   <= 1'b1;
                  state_ff <= S_FILL_RD;
               end else begin
                  run_ff <= run_ff + 1'b1;
               end
               if (!(!bit_now && run_ff + 1'b1 == TW'(cnt_ff))) begin
                  if (pos_ff + 1'b1 >= eff_total) begin
                     st_ff    <= bfa_pkg::ST_NO_SPACE;
                     state_ff <= S_DONE;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= (pos_ff[bfa_pkg::BIT_AW-1:0] == '1) ? S_SCAN_RD : S_SCAN_EV;
                  end
               end
            end
            S_FILL_RD: state_ff <= S_FILL_WAIT;
            S_FILL_WAIT: state_ff <= S_FILL_WR;
            S_FILL_WR: begin
               if (pos_ff + 1'b1 == end_ff) state_ff <= S_DONE;
               else begin
                  pos_ff   <= pos_ff + 1'b1;
                  state_ff <= S_FILL_RD;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
   a_zero_start: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.status != bfa_pkg::ST_OK) |-> rsp.data.start_frame == 12'd0)
      else $error("start nonzero on error");
endmodule
